>>> design/hiwa_pkg.sv
package hiwa_pkg;

  // Coefficient format
  localparam int COEF_BITS = 21;
  localparam int FRAC_BITS = 10;
  localparam int ROW_BITS  = 3 * COEF_BITS;

  // APB register map, 64-bit data, registers at 8*i
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 6;
  localparam int REG_IDX_BITS  = 3;
  localparam int REG_IDX_LSB   = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ROW0     = 3'd0,
    REG_ROW1     = 3'd1,
    REG_ROW2     = 3'd2,
    REG_LAST_COL = 3'd3,
    REG_LAST_ROW = 3'd4
  } hiwa_reg_e;

endpackage

>>> design/hiwa_if.sv
// Input coordinate channel
interface hiwa_in_if #(
  parameter int CW = 12
) ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] dest_x;
  logic [CW-1:0] dest_y;

  modport source (output valid, dest_x, dest_y, input ready);
  modport sink   (input valid, dest_x, dest_y, output ready);
endinterface

// Mapped address channel
interface hiwa_out_if #(
  parameter int CW = 12
) ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] map_x;
  logic [CW-1:0] map_y;
  logic          inside_res;
  logic [CW-1:0] echo_x;
  logic [CW-1:0] echo_y;

  modport source (output valid, map_x, map_y, inside_res, echo_x, echo_y, input ready);
  modport sink   (input valid, map_x, map_y, inside_res, echo_x, echo_y, output ready);
endinterface

>>> design/hiwa_cfg.sv
module hiwa_cfg #(
  parameter int CB = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hiwa_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [hiwa_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [hiwa_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output logic [hiwa_pkg::ROW_BITS-1:0]      row0_o,
  output logic [hiwa_pkg::ROW_BITS-1:0]      row1_o,
  output logic [hiwa_pkg::ROW_BITS-1:0]      row2_o,
  output logic [CB-1:0]                      last_col_o,
  output logic [CB-1:0]                      last_row_o
);
  import hiwa_pkg::*;

  logic [ROW_BITS-1:0] row0_q, row1_q, row2_q;
  logic [CB-1:0]       lcol_q, lrow_q;
  logic                wr_en;
  hiwa_reg_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = hiwa_reg_e'(paddr[REG_IDX_LSB +: REG_IDX_BITS]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= '0;
      row1_q <= '0;
      row2_q <= '0;
      lcol_q <= '0;
      lrow_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW0:     row0_q <= pwdata[ROW_BITS-1:0];
        REG_ROW1:     row1_q <= pwdata[ROW_BITS-1:0];
        REG_ROW2:     row2_q <= pwdata[ROW_BITS-1:0];
        REG_LAST_COL: lcol_q <= pwdata[CB-1:0];
        REG_LAST_ROW: lrow_q <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_ROW0:     prdata = APB_DATA_BITS'(row0_q);
      REG_ROW1:     prdata = APB_DATA_BITS'(row1_q);
      REG_ROW2:     prdata = APB_DATA_BITS'(row2_q);
      REG_LAST_COL: prdata = APB_DATA_BITS'(lcol_q);
      REG_LAST_ROW: prdata = APB_DATA_BITS'(lrow_q);
      default:      prdata = '0;
    endcase
  end

  assign row0_o     = row0_q;
  assign row1_o     = row1_q;
  assign row2_o     = row2_q;
  assign last_col_o = lcol_q;
  assign last_row_o = lrow_q;
endmodule

>>> design/hiwa_dot.sv
// Two stages: six coefficient products, then the three row sums
module hiwa_dot #(
  parameter int CB = 12,
  parameter int DW = 36
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [CB-1:0]                 x_i,
  input  logic [CB-1:0]                 y_i,
  input  logic [hiwa_pkg::ROW_BITS-1:0] row0_i,
  input  logic [hiwa_pkg::ROW_BITS-1:0] row1_i,
  input  logic [hiwa_pkg::ROW_BITS-1:0] row2_i,
  output logic signed [DW-1:0]          nx_o,
  output logic signed [DW-1:0]          ny_o,
  output logic signed [DW-1:0]          w_o
);
  import hiwa_pkg::*;

  localparam int PW = COEF_BITS + CB + 1;

  logic [ROW_BITS-1:0]          rows [3];
  logic signed [CB:0]           xs, ys;
  logic signed [PW-1:0]         px_q [3];
  logic signed [PW-1:0]         py_q [3];
  logic signed [COEF_BITS-1:0]  c2_q [3];
  logic signed [DW-1:0]         sum_q [3];

  assign rows[0] = row0_i;
  assign rows[1] = row1_i;
  assign rows[2] = row2_i;
  assign xs = signed'({1'b0, x_i});
  assign ys = signed'({1'b0, y_i});

  // Stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        px_q[r] <= PW'(signed'(rows[r][0 +: COEF_BITS]) * xs);
        py_q[r] <= PW'(signed'(rows[r][COEF_BITS +: COEF_BITS]) * ys);
        c2_q[r] <= signed'(rows[r][2*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  // Stage 2: sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= DW'(px_q[r]) + DW'(py_q[r]) + DW'(c2_q[r]);
      end
    end
  end

  assign nx_o = sum_q[0];
  assign ny_o = sum_q[1];
  assign w_o  = sum_q[2];
endmodule

>>> design/hiwa_bound.sv
// Three stages: sign fold, bound products, exact bound compare
module hiwa_bound #(
  parameter int CB = 12,
  parameter int DW = 36,
  parameter int RW = 58
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] nx_i,
  input  logic signed [DW-1:0] ny_i,
  input  logic signed [DW-1:0] w_i,
  input  logic [CB-1:0]        last_col_i,
  input  logic [CB-1:0]        last_row_i,
  output logic [RW-1:0]        numx_o,
  output logic [RW-1:0]        numy_o,
  output logic [RW-1:0]        den_o,
  output logic                 inside_o
);
  import hiwa_pkg::*;

  // Stage 3: fold sign of w into the numerators
  logic signed [DW-1:0] nx3_q, ny3_q;
  logic [DW-1:0]        den3_q;
  logic                 nz3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx3_q  <= w_i[DW-1] ? -nx_i : nx_i;
      ny3_q  <= w_i[DW-1] ? -ny_i : ny_i;
      den3_q <= w_i[DW-1] ? DW'(-w_i) : DW'(w_i);
      nz3_q  <= |w_i;
    end
  end

  // Stage 4: last * den for both axes
  logic [DW+CB-1:0] limx4_q, limy4_q;
  logic [DW-2:0]    nx4_q, ny4_q;
  logic             negx4_q, negy4_q, nz4_q;
  logic [DW-1:0]    den4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      limx4_q <= (DW+CB)'(last_col_i) * (DW+CB)'(den3_q);
      limy4_q <= (DW+CB)'(last_row_i) * (DW+CB)'(den3_q);
      nx4_q   <= nx3_q[DW-2:0];
      ny4_q   <= ny3_q[DW-2:0];
      negx4_q <= nx3_q[DW-1];
      negy4_q <= ny3_q[DW-1];
      nz4_q   <= nz3_q;
      den4_q  <= den3_q;
    end
  end

  // Stage 5: 0 <= n/den <= last, numerator carries the 2^10 scale
  logic [RW-1:0] numx, numy, numx5_q, numy5_q, den5_q;
  logic          okx, oky, ins5_q;

  assign numx = RW'({nx4_q, {FRAC_BITS{1'b0}}});
  assign numy = RW'({ny4_q, {FRAC_BITS{1'b0}}});
  assign okx  = !negx4_q && (numx <= RW'(limx4_q));
  assign oky  = !negy4_q && (numy <= RW'(limy4_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx5_q <= numx;
      numy5_q <= numy;
      den5_q  <= RW'(den4_q);
      ins5_q  <= nz4_q & okx & oky;
    end
  end

  assign numx_o   = numx5_q;
  assign numy_o   = numy5_q;
  assign den_o    = den5_q;
  assign inside_o = ins5_q;
endmodule

>>> design/hiwa_div_step.sv
// One restoring division step: resolves quotient bit BIT for both axes
module hiwa_div_step #(
  parameter int CB  = 12,
  parameter int RW  = 58,
  parameter int BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] den_i,
  input  logic [RW-1:0] rx_i,
  input  logic [RW-1:0] ry_i,
  input  logic [CB-1:0] qx_i,
  input  logic [CB-1:0] qy_i,
  output logic [RW-1:0] den_o,
  output logic [RW-1:0] rx_o,
  output logic [RW-1:0] ry_o,
  output logic [CB-1:0] qx_o,
  output logic [CB-1:0] qy_o
);
  logic [RW-1:0] tr;
  logic          gex, gey;
  logic [RW-1:0] den_q, rx_q, ry_q;
  logic [CB-1:0] qx_q, qy_q;

  assign tr  = den_i << BIT;
  assign gex = rx_i >= tr;
  assign gey = ry_i >= tr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rx_q  <= gex ? rx_i - tr : rx_i;
      ry_q  <= gey ? ry_i - tr : ry_i;
      qx_q  <= qx_i | (CB'(gex) << BIT);
      qy_q  <= qy_i | (CB'(gey) << BIT);
    end
  end

  assign den_o = den_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign qx_o  = qx_q;
  assign qy_o  = qy_q;
endmodule

>>> design/homography_inverse_warp_address.sv
// Inverse homography warp address generator. Each destination pixel
// (dest_x, dest_y) is mapped through the 3x3 matrix held in the APB registers
// (rows 0/1 Q10.10, row 2 Q0.20, three 21-bit coefficients per 64-bit
// register at byte offset 8*i) and the source point nx/w, ny/w is returned
// truncated toward zero, with inside_res set when w is nonzero and the exact
// point lies in [0, last_col] x [0, last_row]; otherwise map_x/map_y are 0.
// The pipeline accepts one coordinate every clock while the output is not
// stalled. It has five arithmetic stages (products, sums, sign fold, bound
// products, bound compare) and one restoring-divider stage per quotient bit. The
// whole pipeline advances together and holds when the output transfer is stalled.
module homography_inverse_warp_address #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  hiwa_in_if.sink                            in_if,
  hiwa_out_if.source                         out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hiwa_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [hiwa_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [hiwa_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import hiwa_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = COEF_BITS + CB + 3;
  localparam int RW  = DW + FRAC_BITS + CB;
  localparam int PRE = 5;
  localparam int NST = PRE + CB;

  logic [ROW_BITS-1:0] row0, row1, row2;
  logic [CB-1:0]       last_col, last_row;
  logic                en;

  hiwa_cfg #(.CB(CB)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .row0_o(row0), .row1_o(row1), .row2_o(row2),
    .last_col_o(last_col), .last_row_o(last_row)
  );

  // Whole pipeline moves unless the output holds a result not yet taken
  logic v_q [NST];
  assign en          = !v_q[NST-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_if.valid;
      for (int i = 1; i < NST; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Destination coordinate travels alongside
  logic [CB-1:0] ex_q [NST];
  logic [CB-1:0] ey_q [NST];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q[0] <= in_if.dest_x;
      ey_q[0] <= in_if.dest_y;
      for (int i = 1; i < NST; i++) begin
        ex_q[i] <= ex_q[i-1];
        ey_q[i] <= ey_q[i-1];
      end
    end
  end

  // Dot products
  logic signed [DW-1:0] nx, ny, w;

  hiwa_dot #(.CB(CB), .DW(DW)) u_dot (
    .clk_i, .en_i(en), .x_i(in_if.dest_x), .y_i(in_if.dest_y),
    .row0_i(row0), .row1_i(row1), .row2_i(row2),
    .nx_o(nx), .ny_o(ny), .w_o(w)
  );

  // Bound test
  logic [RW-1:0] den_s [CB+1];
  logic [RW-1:0] rx_s  [CB+1];
  logic [RW-1:0] ry_s  [CB+1];
  logic [CB-1:0] qx_s  [CB+1];
  logic [CB-1:0] qy_s  [CB+1];
  logic          ins_pre;

  hiwa_bound #(.CB(CB), .DW(DW), .RW(RW)) u_bound (
    .clk_i, .en_i(en), .nx_i(nx), .ny_i(ny), .w_i(w),
    .last_col_i(last_col), .last_row_i(last_row),
    .numx_o(rx_s[0]), .numy_o(ry_s[0]), .den_o(den_s[0]), .inside_o(ins_pre)
  );

  assign qx_s[0] = '0;
  assign qy_s[0] = '0;

  // Divider, MSB first
  for (genvar g = 0; g < CB; g++) begin : g_div
    hiwa_div_step #(.CB(CB), .RW(RW), .BIT(CB-1-g)) u_step (
      .clk_i, .en_i(en), .den_i(den_s[g]), .rx_i(rx_s[g]), .ry_i(ry_s[g]),
      .qx_i(qx_s[g]), .qy_i(qy_s[g]),
      .den_o(den_s[g+1]), .rx_o(rx_s[g+1]), .ry_o(ry_s[g+1]),
      .qx_o(qx_s[g+1]), .qy_o(qy_s[g+1])
    );
  end

  // Inside flag follows the divider
  logic ins_q [CB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ins_q[0] <= ins_pre;
      for (int i = 1; i < CB; i++) ins_q[i] <= ins_q[i-1];
    end
  end

  // Output
  assign out_if.valid      = v_q[NST-1];
  assign out_if.inside_res = ins_q[CB-1];
  assign out_if.map_x      = ins_q[CB-1] ? qx_s[CB] : '0;
  assign out_if.map_y      = ins_q[CB-1] ? qy_s[CB] : '0;
  assign out_if.echo_x     = ex_q[NST-1];
  assign out_if.echo_y     = ey_q[NST-1];
endmodule
